@@ hw/rtl/sli_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list package
// Request and response types, operation and status codes, and the states
// of the sorted table sequencer.
// ----------------------------------------------------------------------------
package sli_pkg;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] value;
		logic [3:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [4:0]         entry_count;
		logic signed [31:0] read_value;
		logic signed [31:0] smallest_value;
	} rsp_t;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [2:0] STAT_INSERTED  = 3'd0;
	localparam logic [2:0] STAT_FULL      = 3'd1;
	localparam logic [2:0] STAT_DELETED   = 3'd2;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
	localparam logic [2:0] STAT_READ_OK   = 3'd4;
	localparam logic [2:0] STAT_RANGE     = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_SCAN,
		ST_INS_HEAD,
		ST_DEL_SCAN,
		ST_DEL_SHIFT,
		ST_RD_WAIT,
		ST_RESP
	} state_t;

endpackage
`default_nettype wire

@@ hw/rtl/sli_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/sorted_list_insert_delete.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list with insert, delete and read
// Keeps up to CAPACITY signed 32-bit values in ascending order in one RAM.
// ----------------------------------------------------------------------------
// An insert into a full or empty table, a delete from an empty one, an
// out-of-range read and the unused opcode go straight to the response state;
// a read in range waits for the RAM data; an insert shifts each larger entry
// up one place and a delete scans up through the table. One request is in
// work at a time, so the next is accepted only once its predecessor is done.
// Reset clears the entry count, so the table starts empty; RAM is not cleared.
module sorted_list_insert_delete
	import sli_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output      logic req_stall,
	input  wire req_t req,
	output      logic rsp_valid,
	input  wire logic rsp_stall,
	output      rsp_t rsp
);

	// Address, count and comparison widths follow the capacity.
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 4) ? CW : 4;
	localparam int EW = (CW > 5) ? CW : 5;

	state_t state_q, state_nxt;

	// Request value held for the whole operation.
	logic signed [31:0] val_q;

	// Table bookkeeping: the count lives in a register and the first entry
	// is mirrored here so that every response can report it without a read.
	logic [CW-1:0]      count_q;
	logic signed [31:0] min_q;

	// Address of the entry whose read data arrives in the current cycle.
	logic [AW-1:0] idx_q;

	// Result of the operation, waiting for the response register.
	logic [2:0]         stat_q;
	logic signed [31:0] rdv_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	// RAM port.
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	// Sequencer controls.
	logic          idx_ld;
	logic [AW-1:0] idx_nxt;
	logic          cnt_inc;
	logic          cnt_dec;
	logic          stat_ld;
	logic [2:0]    stat_nxt;
	logic          rdv_ld;

	// Derived conditions.
	logic          accept;
	logic          full;
	logic          empty;
	logic [CW-1:0] cnt_m1;
	logic [PW-1:0] pos_ext;
	logic          pos_ok;
	logic          rd_gt;
	logic          rd_eq;
	logic          idx_last;
	logic          idx_zero;
	logic          rsp_free;
	logic [EW-1:0] cnt_ext;

	sli_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);

	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign cnt_m1   = count_q - CW'(1);
	assign pos_ext  = PW'(req.position);
	assign pos_ok   = (pos_ext < PW'(count_q));
	assign rd_gt    = ($signed(mem_rdata) > val_q);
	assign rd_eq    = ($signed(mem_rdata) == val_q);
	assign idx_last = ((CW'(idx_q) + CW'(1)) == count_q);
	assign idx_zero = (idx_q == '0);
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign cnt_ext  = EW'(count_q);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req.opcode)
						OP_INSERT: state_nxt = (full || empty) ? ST_RESP : ST_INS_SCAN;
						OP_DELETE: state_nxt = empty ? ST_RESP : ST_DEL_SCAN;
						OP_READ:   state_nxt = pos_ok ? ST_RD_WAIT : ST_RESP;
						default:   state_nxt = ST_RESP;
					endcase
				end
			end
			ST_INS_SCAN: begin
				if (rd_gt) begin
					state_nxt = idx_zero ? ST_INS_HEAD : ST_INS_SCAN;
				end else begin
					state_nxt = ST_RESP;
				end
			end
			ST_INS_HEAD: state_nxt = ST_RESP;
			ST_DEL_SCAN: begin
				if (idx_last) begin
					state_nxt = ST_RESP;
				end else if (rd_eq) begin
					state_nxt = ST_DEL_SHIFT;
				end
			end
			ST_DEL_SHIFT: begin
				if (idx_last) begin
					state_nxt = ST_RESP;
				end
			end
			ST_RD_WAIT: state_nxt = ST_RESP;
			ST_RESP: begin
				if (rsp_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs: RAM accesses and bookkeeping updates.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		idx_ld    = 1'b0;
		idx_nxt   = idx_q;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		stat_ld   = 1'b0;
		stat_nxt  = STAT_RANGE;
		rdv_ld    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req.opcode)
						OP_INSERT: begin
							if (full) begin
								stat_ld  = 1'b1;
								stat_nxt = STAT_FULL;
							end else if (empty) begin
								mem_we    = 1'b1;
								mem_wdata = req.value;
								cnt_inc   = 1'b1;
								stat_ld   = 1'b1;
								stat_nxt  = STAT_INSERTED;
							end else begin
								// Walk down from the last entry.
								mem_re    = 1'b1;
								mem_raddr = cnt_m1[AW-1:0];
								idx_ld    = 1'b1;
								idx_nxt   = cnt_m1[AW-1:0];
							end
						end
						OP_DELETE: begin
							if (empty) begin
								stat_ld  = 1'b1;
								stat_nxt = STAT_NOT_FOUND;
							end else begin
								// Walk up from the first entry.
								mem_re  = 1'b1;
								idx_ld  = 1'b1;
								idx_nxt = '0;
							end
						end
						OP_READ: begin
							if (pos_ok) begin
								mem_re    = 1'b1;
								mem_raddr = pos_ext[AW-1:0];
							end else begin
								stat_ld  = 1'b1;
								stat_nxt = STAT_RANGE;
							end
						end
						default: begin
							stat_ld  = 1'b1;
							stat_nxt = STAT_RANGE;
						end
					endcase
				end
			end
			ST_INS_SCAN: begin
				// A larger entry moves up one place; the first entry not
				// larger than the value marks where the value lands, which
				// keeps the value after any equal entries.
				mem_we    = 1'b1;
				mem_waddr = idx_q + AW'(1);
				if (rd_gt) begin
					mem_wdata = mem_rdata;
					if (!idx_zero) begin
						mem_re    = 1'b1;
						mem_raddr = idx_q - AW'(1);
						idx_ld    = 1'b1;
						idx_nxt   = idx_q - AW'(1);
					end
				end else begin
					mem_wdata = val_q;
					cnt_inc   = 1'b1;
					stat_ld   = 1'b1;
					stat_nxt  = STAT_INSERTED;
				end
			end
			ST_INS_HEAD: begin
				// Every entry was larger: the value becomes the first entry.
				mem_we    = 1'b1;
				mem_wdata = val_q;
				cnt_inc   = 1'b1;
				stat_ld   = 1'b1;
				stat_nxt  = STAT_INSERTED;
			end
			ST_DEL_SCAN: begin
				if (idx_last) begin
					stat_ld = 1'b1;
					if (rd_eq) begin
						cnt_dec  = 1'b1;
						stat_nxt = STAT_DELETED;
					end else begin
						stat_nxt = STAT_NOT_FOUND;
					end
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_q + AW'(1);
					idx_ld    = 1'b1;
					idx_nxt   = idx_q + AW'(1);
				end
			end
			ST_DEL_SHIFT: begin
				// Each later entry moves down one place over the hole.
				mem_we    = 1'b1;
				mem_waddr = idx_q - AW'(1);
				mem_wdata = mem_rdata;
				if (idx_last) begin
					cnt_dec  = 1'b1;
					stat_ld  = 1'b1;
					stat_nxt = STAT_DELETED;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_q + AW'(1);
					idx_ld    = 1'b1;
					idx_nxt   = idx_q + AW'(1);
				end
			end
			ST_RD_WAIT: begin
				rdv_ld   = 1'b1;
				stat_ld  = 1'b1;
				stat_nxt = STAT_READ_OK;
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == ST_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= req.value;
			rdv_q <= '0;
		end
		if (idx_ld) begin
			idx_q <= idx_nxt;
		end
		if (stat_ld) begin
			stat_q <= stat_nxt;
		end
		if (rdv_ld) begin
			rdv_q <= $signed(mem_rdata);
		end
		// Any write to the first entry updates the mirrored smallest value.
		if (mem_we && mem_waddr == '0) begin
			min_q <= $signed(mem_wdata);
		end
		if (state_q == ST_RESP && rsp_free) begin
			rsp_q.status         <= stat_q;
			rsp_q.entry_count    <= cnt_ext[4:0];
			rsp_q.read_value     <= rdv_q;
			rsp_q.smallest_value <= empty ? 32'sd0 : min_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The scan and shift never read and write the same entry in one cycle.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("RAM read and write hit the same entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_inc || cnt_dec) |=> (state_q == ST_RESP))
		else $error("count changed without finishing the operation");

	a_shift_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEL_SHIFT) |-> (mem_we && mem_waddr != idx_q))
		else $error("delete shift did not write the previous entry");

endmodule
`default_nettype wire

@@ verif/tb_sorted_list_insert_delete.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted list insert / delete / read testbench
// Sends insert, delete and read requests to the sorted table, including
// random idle gaps on the request side and random stalls on the response
// side. A scoreboard keeps its own sorted copy of the table, predicts each
// response when its request is accepted, and checks every response field
// by field, in order.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_delete;
	import sli_pkg::*;

	localparam int CAPACITY = 16;

	// Opcode 3 has no meaning. The block must treat it as a no-op that
	// reports an out-of-range status.
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam int RANDOM_ITEMS   = 400;
	localparam int PHASE_ITEMS    = 40;
	localparam int PAUSE_ITEM     = 250;
	localparam int HOLD_AFTER_RSP = 120;
	localparam int HOLD_CYCLES    = 300;
	// The slowest requests, an insert at the head of a nearly full table or a
	// delete from a full one, walk the whole table, so this is a comfortable margin.
	localparam int DRAIN_CYCLES   = 40;
	// Cycles with no accepted request or response before the run gives up.
	// This has to cover the long response hold-off plus one request's latency.
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

	// ------------------------------------------------------------------------
	// Scoreboard: a sorted queue that mirrors the table, and the list of
	// responses that are still owed by the block.
	// ------------------------------------------------------------------------
	class sorted_table_scoreboard;
		logic signed [31:0] entries[$];
		rsp_t               expected_rsps[$];
		int                 mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Applies an accepted request to the mirror and queues its response.
		function void note_request(req_t r);
			rsp_t               exp;
			logic signed [31:0] val;
			int                 slot;
			exp = '0;
			exp.status = STAT_RANGE;
			val = r.value;
			case (r.opcode)
				OP_INSERT: begin
					if (entries.size() >= CAPACITY) begin
						exp.status = STAT_FULL;
					end else begin
						slot = 0;
						while (slot < entries.size() && entries[slot] < val)
							slot++;
						entries.insert(slot, val);
						exp.status = STAT_INSERTED;
					end
				end
				OP_DELETE: begin
					slot = 0;
					while (slot < entries.size() && entries[slot] != val)
						slot++;
					if (slot < entries.size()) begin
						entries.delete(slot);
						exp.status = STAT_DELETED;
					end else begin
						exp.status = STAT_NOT_FOUND;
					end
				end
				OP_READ: begin
					if (int'(r.position) < entries.size()) begin
						exp.read_value = entries[r.position];
						exp.status = STAT_READ_OK;
					end
				end
				default: begin
					exp.status = STAT_RANGE;
				end
			endcase
			exp.entry_count = 5'(entries.size());
			exp.smallest_value = (entries.size() > 0) ? entries[0] : 32'sd0;
			expected_rsps.push_back(exp);
		endfunction

		// Four-state compare, so unknown bits in a response count as errors.
		function void compare_field(string name, logic signed [31:0] exp,
			logic signed [31:0] act);
			if (exp !== act) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, name, exp, act);
				mismatches++;
			end
		endfunction

		function void check_response(rsp_t act);
			rsp_t exp;
			if (expected_rsps.size() == 0) begin
				$display("%0t: response with none expected, actual status %0d",
					$time, act.status);
				mismatches++;
				return;
			end
			exp = expected_rsps.pop_front();
			compare_field("status", exp.status, act.status);
			compare_field("entry_count", exp.entry_count, act.entry_count);
			compare_field("read_value", exp.read_value, act.read_value);
			compare_field("smallest_value", exp.smallest_value, act.smallest_value);
		endfunction

		// A value that is currently stored, so a delete will find it, or the fallback if the table is empty.
		function logic signed [31:0] pick_stored(logic signed [31:0] fallback);
			if (entries.size() == 0)
				return fallback;
			return entries[$urandom_range(0, entries.size() - 1)];
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	sorted_table_scoreboard scoreboard = new();

	int  rsp_seen    = 0;
	int  idle_cycles = 0;
	bit  sender_quiet;

	sorted_list_insert_delete #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Gap lengths: mostly none or a few cycles, now and then a long one.
	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic req_t make_request(logic [1:0] op, logic signed [31:0] val,
		logic [3:0] pos);
		req_t r;
		r.opcode = op;
		r.value = val;
		r.position = pos;
		return r;
	endfunction

	// Values cluster in a narrow band so that duplicates and delete hits are
	// common; the extremes and fully random patterns exercise the sign
	// handling and every value bit.
	function automatic logic signed [31:0] random_value();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return 32'(int'($urandom_range(0, 16)) - 8);
		if (pick < 55) begin
			case ($urandom_range(0, 3))
				0: return INT_MIN;
				1: return INT_MAX;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	// Filling phases mostly insert, so the table runs into its capacity and
	// the full case is hit. Draining phases mostly delete stored values, so
	// the table empties again.
	function automatic req_t random_request(bit filling);
		req_t r;
		int   pick;
		int   count;
		count = scoreboard.entries.size();
		pick = $urandom_range(0, 99);
		r.value = random_value();
		r.position = 4'($urandom_range(0, 15));
		if (filling)
			r.opcode = (pick < 75) ? OP_INSERT : (pick < 87) ? OP_DELETE :
				(pick < 97) ? OP_READ : OP_NONE;
		else
			r.opcode = (pick < 15) ? OP_INSERT : (pick < 70) ? OP_DELETE :
				(pick < 95) ? OP_READ : OP_NONE;
		if (r.opcode == OP_DELETE && $urandom_range(0, 99) < 85)
			r.value = scoreboard.pick_stored(r.value);
		if (r.opcode == OP_READ && count > 0 && $urandom_range(0, 99) < 70)
			r.position = 4'($urandom_range(0, count - 1));
		return r;
	endfunction

	// Offers one request and holds it until the block accepts it. The valid
	// only drops during an idle gap, never between back-to-back requests.
	// The stall is sampled mid-cycle, where it has settled for the coming edge.
	task automatic send_request(req_t r);
		int gap;
		bit stalled;
		gap = sender_quiet ? 0 : idle_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do begin
			@(negedge clk);
			stalled = req_stall;
			@(posedge clk);
		end while (stalled);
		scoreboard.note_request(r);
	endtask

	// ------------------------------------------------------------------------
	// Response side: checks every accepted response and drives the stall.
	// Once enough responses have been seen, it holds off for a long stretch
	// while the sender keeps offering requests, so the block has to back up
	// and stall its request input. The handshake is sampled mid-cycle.
	// ------------------------------------------------------------------------
	initial begin
		int   stall_left;
		int   hold_left;
		int   cycle_count;
		bit   hold_done;
		bit   take;
		rsp_t seen;
		stall_left = 0;
		hold_left = 0;
		cycle_count = 0;
		hold_done = 1'b0;
		rsp_stall <= 1'b0;
		forever begin
			@(negedge clk);
			take = arst_n && rsp_valid && !rsp_stall;
			seen = rsp;
			@(posedge clk);
			cycle_count++;
			if (take) begin
				scoreboard.check_response(seen);
				rsp_seen++;
			end
			if (!hold_done && rsp_seen >= HOLD_AFTER_RSP) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				// In every fourth window of the cycle count, no new random stall is started.
				stall_left = ((cycle_count / 200) % 4 == 0) ? 0 : idle_gap();
			end
		end
	end

	// Watchdog: any accepted request or response restarts the count. It looks
	// mid-cycle, where the handshake signals have settled.
	always @(negedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Request side: reset, a short directed sequence, then random phases.
	// ------------------------------------------------------------------------
	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		sender_quiet = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An empty table: a read is out of range, a delete finds nothing,
		// and the meaningless opcode does nothing.
		send_request(make_request(OP_READ, 32'sd0, 4'd0));
		send_request(make_request(OP_DELETE, 32'sd5, 4'd0));
		send_request(make_request(OP_NONE, -32'sd1, 4'hF));

		// Extremes and a duplicate; the smallest value moves as they land.
		send_request(make_request(OP_INSERT, 32'sd0, 4'd0));
		send_request(make_request(OP_INSERT, -32'sd1, 4'd0));
		send_request(make_request(OP_INSERT, INT_MAX, 4'd0));
		send_request(make_request(OP_INSERT, INT_MIN, 4'd0));
		send_request(make_request(OP_INSERT, 32'sd0, 4'd0));
		send_request(make_request(OP_INSERT, 32'sd7, 4'd0));

		// Reads at the ends of the table, just past it and at the top index.
		send_request(make_request(OP_READ, 32'sd0, 4'd0));
		send_request(make_request(OP_READ, 32'sd0, 4'd5));
		send_request(make_request(OP_READ, 32'sd0, 4'd6));
		send_request(make_request(OP_READ, INT_MAX, 4'hF));
		send_request(make_request(OP_NONE, INT_MIN, 4'd2));

		// Delete both copies of a duplicate, then once more with none left,
		// then the smallest entry, then a value that was never stored.
		send_request(make_request(OP_DELETE, 32'sd0, 4'd0));
		send_request(make_request(OP_DELETE, 32'sd0, 4'd0));
		send_request(make_request(OP_DELETE, 32'sd0, 4'd0));
		send_request(make_request(OP_DELETE, INT_MIN, 4'd0));
		send_request(make_request(OP_DELETE, 32'sd12345, 4'd0));
		send_request(make_request(OP_READ, 32'sd0, 4'd0));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Once, let the block drain completely before going on.
			if (n == PAUSE_ITEM) begin
				req_valid <= 1'b0;
				do @(posedge clk); while (scoreboard.expected_rsps.size() != 0);
			end
			sender_quiet = (n % 100) < 30;
			send_request(random_request((n / PHASE_ITEMS) % 2 == 0));
		end
		req_valid <= 1'b0;

		do @(posedge clk); while (scoreboard.expected_rsps.size() != 0);
		// Give a stray extra response the chance to show up.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (scoreboard.mismatches == 0 && scoreboard.expected_rsps.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/sli_pkg.sv
hw/rtl/sli_ram.sv
hw/rtl/sorted_list_insert_delete.sv
verif/tb_sorted_list_insert_delete.sv
